// File: rtl/gprdz_pkg.sv
// Shared constants and types for the gamepad radial deadzone conditioner.
package gprdz_pkg;

  typedef logic [1:0] cfg_idx_t;

  localparam cfg_idx_t CFG_LEFT_DZ  = 2'd0;
  localparam cfg_idx_t CFG_RIGHT_DZ = 2'd1;
  localparam cfg_idx_t CFG_CAP      = 2'd2;
  localparam cfg_idx_t CFG_TRIG_TH  = 2'd3;

  localparam logic [14:0] LEFT_DZ_RST  = 15'd7849;
  localparam logic [14:0] RIGHT_DZ_RST = 15'd8689;
  localparam logic [15:0] CAP_RST      = 16'd32000;
  localparam logic [7:0]  TRIG_TH_RST  = 8'd30;

  localparam logic [15:0] Q15_MAX = 16'h7FFF;
  localparam logic [15:0] S_FULL  = 16'h8000;

  localparam int OUT_W = 144;

endpackage

// File: rtl/gprdz_stick.sv
// Bit-serial radial deadzone for one stick: square sum, square root, scale, divide.
module gprdz_stick import gprdz_pkg::*; #(
  parameter int AXIS_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [AXIS_BITS-1:0] in_x,
  input  logic [AXIS_BITS-1:0] in_y,
  input  logic [14:0]          dz,
  input  logic [15:0]          cap,
  output logic                 done,
  output logic [15:0]          out_x,
  output logic [15:0]          out_y
);

  localparam int AB  = AXIS_BITS;
  localparam int NW  = 2 * AB;
  localparam int PW  = AB + 16;
  localparam int CW  = $clog2(AB + 17);
  localparam int CMW = ((AB > 16) ? AB : 16) + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_SQ, S_SQRT, S_DEC, S_DIV, S_MUL, S_QLD, S_QDIV, S_FIN, S_DONE
  } st_t;

  st_t           state_r;
  logic [CW-1:0] cnt_r;
  logic [AB-1:0] ax_r, ay_r, mbx_r, mby_r, root_r, qrx_r, qry_r;
  logic          negx_r, negy_r;
  logic [14:0]   dz_r;
  logic [15:0]   cap_r, s_r, sb_r, qx_r, qy_r, out_x_r, out_y_r;
  logic [NW-1:0] acc_r, adx_r, ady_r;
  logic [AB+2:0] rem_r;
  logic [16:0]   drem_r;
  logic [PW-1:0] px_r, py_r, mx_r, my_r;

  logic [NW-1:0]  sq_sum;
  logic [AB+2:0]  rem_sh, trial;
  logic           sq_ge;
  logic [15:0]    dd;
  logic [16:0]    dt;
  logic           d_ge;
  logic [AB:0]    tx, ty, rext;
  logic           qx_ge, qy_ge;
  logic [CMW-1:0] root_w, dz_w, cap_w;
  logic [15:0]    cx, cy;
  logic [AB-1:0]  abs_x, abs_y;

  assign abs_x  = in_x[AB-1] ? (~in_x + 1'b1) : in_x;
  assign abs_y  = in_y[AB-1] ? (~in_y + 1'b1) : in_y;
  assign sq_sum = acc_r + (mbx_r[0] ? adx_r : '0) + (mby_r[0] ? ady_r : '0);
  assign rem_sh = {rem_r[AB:0], acc_r[NW-1:NW-2]};
  assign trial  = {1'b0, root_r, 2'b01};
  assign sq_ge  = rem_sh >= trial;
  assign dd     = cap_r - {1'b0, dz_r};
  assign dt     = {drem_r[15:0], 1'b0};
  assign d_ge   = dt >= {1'b0, dd};
  assign rext   = {1'b0, root_r};
  assign tx     = {qrx_r, px_r[15]};
  assign ty     = {qry_r, py_r[15]};
  assign qx_ge  = tx >= rext;
  assign qy_ge  = ty >= rext;
  assign root_w = CMW'(root_r);
  assign dz_w   = CMW'(dz_r);
  assign cap_w  = CMW'(cap_r);
  assign cx     = (qx_r > Q15_MAX) ? Q15_MAX : qx_r;
  assign cy     = (qy_r > Q15_MAX) ? Q15_MAX : qy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      unique case (state_r)
        S_IDLE, S_DONE: begin
          if (start) begin
            negx_r  <= in_x[AB-1];
            negy_r  <= in_y[AB-1];
            ax_r    <= abs_x;
            ay_r    <= abs_y;
            mbx_r   <= abs_x;
            mby_r   <= abs_y;
            adx_r   <= NW'(abs_x);
            ady_r   <= NW'(abs_y);
            acc_r   <= '0;
            dz_r    <= dz;
            cap_r   <= cap;
            cnt_r   <= CW'(AB);
            state_r <= S_SQ;
          end
        end
        S_SQ: begin
          acc_r <= sq_sum;
          adx_r <= adx_r << 1;
          ady_r <= ady_r << 1;
          mbx_r <= mbx_r >> 1;
          mby_r <= mby_r >> 1;
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == CW'(1)) begin
            rem_r   <= '0;
            root_r  <= '0;
            cnt_r   <= CW'(AB);
            state_r <= S_SQRT;
          end
        end
        S_SQRT: begin
          acc_r  <= acc_r << 2;
          rem_r  <= sq_ge ? (rem_sh - trial) : rem_sh;
          root_r <= {root_r[AB-2:0], sq_ge};
          cnt_r  <= cnt_r - 1'b1;
          if (cnt_r == CW'(1))
            state_r <= S_DEC;
        end
        S_DEC: begin
          if (root_w <= dz_w) begin
            out_x_r <= '0;
            out_y_r <= '0;
            state_r <= S_DONE;
          end else if (cap_w <= dz_w || root_w >= cap_w) begin
            sb_r    <= S_FULL;
            mx_r    <= PW'(ax_r);
            my_r    <= PW'(ay_r);
            px_r    <= '0;
            py_r    <= '0;
            cnt_r   <= CW'(16);
            state_r <= S_MUL;
          end else begin
            drem_r  <= 17'(root_w - dz_w);
            s_r     <= '0;
            cnt_r   <= CW'(15);
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          drem_r <= d_ge ? (dt - {1'b0, dd}) : dt;
          s_r    <= {s_r[14:0], d_ge};
          cnt_r  <= cnt_r - 1'b1;
          if (cnt_r == CW'(1)) begin
            sb_r    <= {s_r[14:0], d_ge};
            mx_r    <= PW'(ax_r);
            my_r    <= PW'(ay_r);
            px_r    <= '0;
            py_r    <= '0;
            cnt_r   <= CW'(16);
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          px_r  <= px_r + (sb_r[0] ? mx_r : '0);
          py_r  <= py_r + (sb_r[0] ? my_r : '0);
          mx_r  <= mx_r << 1;
          my_r  <= my_r << 1;
          sb_r  <= sb_r >> 1;
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == CW'(1))
            state_r <= S_QLD;
        end
        S_QLD: begin
          qrx_r   <= px_r[PW-1:16];
          qry_r   <= py_r[PW-1:16];
          qx_r    <= '0;
          qy_r    <= '0;
          cnt_r   <= CW'(16);
          state_r <= S_QDIV;
        end
        S_QDIV: begin
          qrx_r <= qx_ge ? AB'(tx - rext) : tx[AB-1:0];
          qry_r <= qy_ge ? AB'(ty - rext) : ty[AB-1:0];
          qx_r  <= {qx_r[14:0], qx_ge};
          qy_r  <= {qy_r[14:0], qy_ge};
          px_r  <= px_r << 1;
          py_r  <= py_r << 1;
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == CW'(1))
            state_r <= S_FIN;
        end
        S_FIN: begin
          out_x_r <= negx_r ? (16'd0 - cx) : cx;
          out_y_r <= negy_r ? (16'd0 - cy) : cy;
          state_r <= S_DONE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign done  = (state_r == S_DONE);
  assign out_x = out_x_r;
  assign out_y = out_y_r;

endmodule

// File: rtl/gamepad_radial_deadzone_conditioner.sv
// Top level: gamepad poll conditioner with config registers and stream ports.
// One poll is taken at a time. Its result comes latest when a stick needs the scale
// divide, sooner when the slower stick is at full deflection, and soonest when both
// sticks sit in their deadzones. The delay follows from the bit-serial square, square
// root, scale divide, multiply and divide chain of each stick unit; both sticks and
// both triggers run side by side. A new poll can be taken the cycle after the previous
// result enters the output register, and a stalled output holds the next load.
module gamepad_radial_deadzone_conditioner import gprdz_pkg::*; #(
  parameter int AXIS_BITS = 16,
  localparam int IN_W = ((4 * AXIS_BITS + 32 + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  // left_x, left_y, right_x, right_y, left_trig_raw, right_trig_raw, button_word
  input  logic [IN_W-1:0]   in_tdata,
  // connected
  input  logic              in_tuser,
  output logic              out_tvalid,
  input  logic              out_tready,
  // left_out_x, left_out_y, right_out_x, right_out_y, left_trig_level,
  // right_trig_level, held_buttons, pressed_buttons, released_buttons
  output logic [OUT_W-1:0]  out_tdata,
  // device_present
  output logic              out_tuser,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  cfg_idx_t          cfg_index,
  input  logic [15:0]       cfg_data
);

  localparam int AB = AXIS_BITS;

  typedef enum logic {T_IDLE, T_RUN} tst_t;

  tst_t             state_r;
  logic [14:0]      ldz_r, rdz_r;
  logic [15:0]      cap_r;
  logic [7:0]       thr_r;
  logic [15:0]      last_r, held_r, press_r, rel_r;
  logic             conn_r;
  logic [4:0]       tcnt_r;
  logic [7:0]       trem_r [2];
  logic [7:0]       tdiv_r [2];
  logic [15:0]      tlow_r [2];
  logic [15:0]      tq_r   [2];
  logic             tz_r   [2];
  logic [OUT_W-1:0] out_tdata_r;
  logic             out_valid_r, out_tuser_r;

  logic             accept, fin, load;
  logic             l_done, r_done;
  logic [15:0]      lx, ly, rx, ry, btn;
  logic [7:0]       traw [2];
  logic [8:0]       tt   [2];
  logic             tge  [2];
  logic [7:0]       td   [2];
  logic [23:0]      tdvd [2];
  logic [15:0]      tlev [2];

  assign accept    = in_tvalid && in_tready;
  assign in_tready = (state_r == T_IDLE);
  assign cfg_ready = 1'b1;
  assign btn       = in_tdata[4*AB+31:4*AB+16];
  assign traw[0]   = in_tdata[4*AB+7:4*AB];
  assign traw[1]   = in_tdata[4*AB+15:4*AB+8];

  gprdz_stick #(.AXIS_BITS(AB)) u_left (
    .clk, .rst_n, .start(accept),
    .in_x(in_tdata[AB-1:0]), .in_y(in_tdata[2*AB-1:AB]),
    .dz(ldz_r), .cap(cap_r), .done(l_done), .out_x(lx), .out_y(ly)
  );

  gprdz_stick #(.AXIS_BITS(AB)) u_right (
    .clk, .rst_n, .start(accept),
    .in_x(in_tdata[3*AB-1:2*AB]), .in_y(in_tdata[4*AB-1:3*AB]),
    .dz(rdz_r), .cap(cap_r), .done(r_done), .out_x(rx), .out_y(ry)
  );

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      tt[i]   = {trem_r[i], tlow_r[i][15]};
      tge[i]  = tt[i] >= {1'b0, tdiv_r[i]};
      td[i]   = (traw[i] > thr_r) ? (traw[i] - thr_r) : 8'd0;
      tdvd[i] = {td[i], 16'd0} - 24'(td[i]);
      tlev[i] = tz_r[i] ? 16'd0 : tq_r[i];
    end
  end

  assign fin  = l_done && r_done && (tcnt_r == 5'd0);
  assign load = (state_r == T_RUN) && fin && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= T_IDLE;
      out_valid_r <= 1'b0;
      tcnt_r      <= '0;
      last_r      <= '0;
      ldz_r       <= LEFT_DZ_RST;
      rdz_r       <= RIGHT_DZ_RST;
      cap_r       <= CAP_RST;
      thr_r       <= TRIG_TH_RST;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_LEFT_DZ:  ldz_r <= cfg_data[14:0];
          CFG_RIGHT_DZ: rdz_r <= cfg_data[14:0];
          CFG_CAP:      cap_r <= cfg_data;
          CFG_TRIG_TH:  thr_r <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (out_valid_r && out_tready && !load)
        out_valid_r <= 1'b0;
      unique case (state_r)
        T_IDLE: begin
          if (accept) begin
            conn_r  <= in_tuser;
            held_r  <= btn;
            press_r <= btn & ~last_r;
            rel_r   <= ~btn & last_r;
            if (in_tuser)
              last_r <= btn;
            for (int i = 0; i < 2; i++) begin
              tz_r[i]   <= (traw[i] <= thr_r);
              trem_r[i] <= tdvd[i][23:16];
              tlow_r[i] <= tdvd[i][15:0];
              tdiv_r[i] <= 8'd255 - thr_r;
              tq_r[i]   <= '0;
            end
            tcnt_r  <= 5'd16;
            state_r <= T_RUN;
          end
        end
        T_RUN: begin
          if (tcnt_r != 5'd0) begin
            for (int i = 0; i < 2; i++) begin
              trem_r[i] <= tge[i] ? 8'(tt[i] - {1'b0, tdiv_r[i]}) : tt[i][7:0];
              tq_r[i]   <= {tq_r[i][14:0], tge[i]};
              tlow_r[i] <= tlow_r[i] << 1;
            end
            tcnt_r <= tcnt_r - 1'b1;
          end
          if (load) begin
            out_valid_r <= 1'b1;
            out_tuser_r <= conn_r;
            out_tdata_r <= conn_r ?
              {rel_r, press_r, held_r, tlev[1], tlev[0], ry, rx, ly, lx} : '0;
            state_r     <= T_IDLE;
          end
        end
        default: state_r <= T_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_tready)
    else $error("item accepted while one is in flight");

  a_absent_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata == '0))
    else $error("absent device gave nonzero result");

  a_hist_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !in_tuser) |=> $stable(last_r))
    else $error("button history moved on absent poll");

  a_edges_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ((out_tdata[127:112] & out_tdata[143:128]) == 16'd0))
    else $error("button pressed and released at once");

endmodule
